@@ src/mcsql_pkg.sv @@
package mcsql_pkg;

    localparam int NUM_CPUS_DEF = 16;

    localparam int ACTION_W = 2;
    localparam int CPU_W    = 4;
    localparam int STATUS_W = 3;

    localparam logic [ACTION_W-1:0] ACT_ACQUIRE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CANCEL  = 2'd2;

    localparam logic [1:0] CS_IDLE  = 2'd0;
    localparam logic [1:0] CS_WAIT  = 2'd1;
    localparam logic [1:0] CS_OWNER = 2'd2;

    localparam logic [STATUS_W-1:0] R_ACQUIRED  = 3'd0;
    localparam logic [STATUS_W-1:0] R_QUEUED    = 3'd1;
    localparam logic [STATUS_W-1:0] R_FREED     = 3'd2;
    localparam logic [STATUS_W-1:0] R_HANDOFF   = 3'd3;
    localparam logic [STATUS_W-1:0] R_CANCELLED = 3'd4;
    localparam logic [STATUS_W-1:0] R_OWNER     = 3'd5;
    localparam logic [STATUS_W-1:0] R_ERROR     = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHK,
        ST_RMW_P,
        ST_RMW_N,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [CPU_W-1:0]    hc;
        logic                hv;
        logic [STATUS_W-1:0] status;
    } t_result;

endpackage

@@ src/mcs_queue_lock_with_cancel.sv @@
// Queue lock manager with cancel. Each request names a processor and an action
// (acquire, release, cancel) and produces exactly one result: acquired, queued,
// freed, handed off (with the new owner), cancelled, already owner, or error.
// Illegal requests report error and leave the queue untouched. Per-processor
// successor/predecessor/status records live in one synchronous RAM; the tail
// link is a register. A request passes through these steps from acceptance until
// the next one can be accepted: a check of the requester's record (read at
// acceptance), a read-modify-write step each for the predecessor and the
// successor when they change, a step that hands the result to the output
// register, and an idle step in which the next request is taken; a full
// output register stretches the hand-off step. All go through the RAM's single
// read and single write port. Reset brings every record to zero at once through
// per-entry valid bits; no clearing pass is needed.
module mcs_queue_lock_with_cancel #(
    parameter int NUM_CPUS = mcsql_pkg::NUM_CPUS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // action[1:0], cpu[5:2], zero[7:6]
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // status[2:0], handoff_valid[3], handoff_cpu[7:4]
);

    logic               res_valid;
    logic               res_ready;
    mcsql_pkg::t_result res;

    logic               r_out_valid;
    mcsql_pkg::t_result r_out;

    mcsql_ctrl #(
        .NUM_CPUS (NUM_CPUS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_action    (s_axis_tdata[1:0]),
        .i_cpu       (s_axis_tdata[5:2]),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.hc, r_out.hv, r_out.status};

endmodule

@@ src/mcsql_ram.sv @@
module mcsql_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = mcsql_pkg::NUM_CPUS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/mcsql_ctrl.sv @@
module mcsql_ctrl #(
    parameter int NUM_CPUS = mcsql_pkg::NUM_CPUS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_req_valid,
    output logic                                o_req_ready,
    input  logic [mcsql_pkg::ACTION_W-1:0]      i_action,
    input  logic [mcsql_pkg::CPU_W-1:0]         i_cpu,
    output logic                                o_res_valid,
    input  logic                                i_res_ready,
    output mcsql_pkg::t_result                  o_res
);

    localparam int AW = $clog2(NUM_CPUS);
    localparam int LW = $clog2(NUM_CPUS + 1);

    typedef struct packed {
        logic [1:0]    st;
        logic [LW-1:0] prev;
        logic [LW-1:0] nxt;
    } t_rec;

    localparam int RW = $bits(t_rec);

    function automatic logic link_ok(input logic [LW-1:0] l);
        return (l != '0) && (int'(l) <= NUM_CPUS);
    endfunction

    function automatic logic [AW-1:0] link_idx(input logic [LW-1:0] l);
        logic [LW-1:0] d;
        d = l - LW'(1);
        return AW'(d);
    endfunction

    mcsql_pkg::t_state r_state, n_state;

    logic [mcsql_pkg::ACTION_W-1:0] r_action;
    logic [mcsql_pkg::CPU_W-1:0]    r_cpu;
    logic [LW-1:0]                  r_tail, n_tail;
    logic [NUM_CPUS-1:0]            r_valid;
    logic                           r_rd_hit;

    logic                n_need_p;
    logic [AW-1:0]       r_p_addr, n_p_addr;
    logic [LW-1:0]       r_p_next, n_p_next;
    logic                r_need_n, n_need_n;
    logic [AW-1:0]       r_n_addr, n_n_addr;
    logic [LW-1:0]       r_n_prev, n_n_prev;
    logic                r_n_own,  n_n_own;
    mcsql_pkg::t_result  r_res,    n_res;

    logic          wr_c;
    t_rec          c_new;

    logic          we, re;
    logic [AW-1:0] waddr, raddr;
    t_rec          wdata;
    logic [RW-1:0] ram_q;
    t_rec          rd;

    logic [AW-1:0] cpu_addr;
    logic [LW-1:0] me;
    logic          in_range;

    assign rd       = r_rd_hit ? t_rec'(ram_q) : '0;
    assign cpu_addr = AW'(r_cpu);
    assign me       = LW'(r_cpu) + LW'(1);
    assign in_range = int'(r_cpu) < NUM_CPUS;

    mcsql_ram #(
        .WIDTH (RW),
        .DEPTH (NUM_CPUS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (ram_q)
    );

    // decision on the requester's record, valid in ST_CHK
    always_comb begin
        n_res        = '{hc: '0, hv: 1'b0, status: mcsql_pkg::R_ERROR};
        wr_c         = 1'b0;
        c_new        = '0;
        n_tail       = r_tail;
        n_need_p     = 1'b0;
        n_p_addr     = link_idx(r_tail);
        n_p_next     = '0;
        n_need_n     = 1'b0;
        n_n_addr     = link_idx(rd.nxt);
        n_n_prev     = '0;
        n_n_own      = 1'b0;
        if (in_range) begin
            unique case (r_action)
                mcsql_pkg::ACT_ACQUIRE: begin
                    if (rd.st == mcsql_pkg::CS_IDLE) begin
                        wr_c   = 1'b1;
                        n_tail = me;
                        if (!link_ok(r_tail)) begin
                            c_new      = '{st: mcsql_pkg::CS_OWNER, prev: '0, nxt: '0};
                            n_res.status = mcsql_pkg::R_ACQUIRED;
                        end else begin
                            c_new      = '{st: mcsql_pkg::CS_WAIT, prev: r_tail, nxt: '0};
                            n_need_p   = 1'b1;
                            n_p_addr   = link_idx(r_tail);
                            n_p_next   = me;
                            n_res.status = mcsql_pkg::R_QUEUED;
                        end
                    end
                end
                mcsql_pkg::ACT_RELEASE: begin
                    if (rd.st == mcsql_pkg::CS_OWNER) begin
                        wr_c = 1'b1;
                        if (r_tail == me || !link_ok(rd.nxt)) begin
                            if (r_tail == me) begin
                                n_tail = '0;
                            end
                            n_res.status = mcsql_pkg::R_FREED;
                        end else begin
                            n_need_n     = 1'b1;
                            n_n_prev     = '0;
                            n_n_own      = 1'b1;
                            n_res.status = mcsql_pkg::R_HANDOFF;
                            n_res.hv     = 1'b1;
                            n_res.hc     = mcsql_pkg::CPU_W'(link_idx(rd.nxt));
                        end
                    end
                end
                mcsql_pkg::ACT_CANCEL: begin
                    if (rd.st == mcsql_pkg::CS_OWNER) begin
                        n_res.status = mcsql_pkg::R_OWNER;
                    end else if (rd.st == mcsql_pkg::CS_WAIT) begin
                        wr_c         = 1'b1;
                        n_res.status = mcsql_pkg::R_CANCELLED;
                        n_need_p     = link_ok(rd.prev);
                        n_p_addr     = link_idx(rd.prev);
                        n_p_next     = '0;
                        if (r_tail == me) begin
                            n_tail = rd.prev;
                        end else if (link_ok(rd.nxt)) begin
                            n_need_n = 1'b1;
                            n_n_prev = rd.prev;
                            n_p_next = rd.nxt;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mcsql_pkg::ST_IDLE: begin
                if (i_req_valid) begin
                    n_state = mcsql_pkg::ST_CHK;
                end
            end
            mcsql_pkg::ST_CHK: begin
                if (n_need_p) begin
                    n_state = mcsql_pkg::ST_RMW_P;
                end else if (n_need_n) begin
                    n_state = mcsql_pkg::ST_RMW_N;
                end else begin
                    n_state = mcsql_pkg::ST_DONE;
                end
            end
            mcsql_pkg::ST_RMW_P: begin
                n_state = r_need_n ? mcsql_pkg::ST_RMW_N : mcsql_pkg::ST_DONE;
            end
            mcsql_pkg::ST_RMW_N: begin
                n_state = mcsql_pkg::ST_DONE;
            end
            mcsql_pkg::ST_DONE: begin
                if (i_res_ready) begin
                    n_state = mcsql_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mcsql_pkg::ST_IDLE;
            end
        endcase
    end

    // memory port and handshake outputs
    always_comb begin
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;
        re          = 1'b0;
        raddr       = AW'(i_cpu);
        we          = 1'b0;
        waddr       = cpu_addr;
        wdata       = c_new;
        unique case (r_state)
            mcsql_pkg::ST_IDLE: begin
                o_req_ready = 1'b1;
                re          = i_req_valid;
            end
            mcsql_pkg::ST_CHK: begin
                we    = wr_c;
                re    = n_need_p || n_need_n;
                raddr = n_need_p ? n_p_addr : n_n_addr;
            end
            mcsql_pkg::ST_RMW_P: begin
                we    = 1'b1;
                waddr = r_p_addr;
                wdata = '{st: rd.st, prev: rd.prev, nxt: r_p_next};
                re    = r_need_n;
                raddr = r_n_addr;
            end
            mcsql_pkg::ST_RMW_N: begin
                we    = 1'b1;
                waddr = r_n_addr;
                wdata = '{st: r_n_own ? mcsql_pkg::CS_OWNER : rd.st,
                          prev: r_n_prev, nxt: rd.nxt};
            end
            mcsql_pkg::ST_DONE: begin
                o_res_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_res = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mcsql_pkg::ST_IDLE;
            r_tail   <= '0;
            r_valid  <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            r_state <= n_state;
            if (re) begin
                r_rd_hit <= r_valid[raddr];
            end
            if (we) begin
                r_valid[waddr] <= 1'b1;
            end
            if (r_state == mcsql_pkg::ST_CHK) begin
                r_tail <= n_tail;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == mcsql_pkg::ST_IDLE && i_req_valid) begin
            r_action <= i_action;
            r_cpu    <= i_cpu;
        end
        if (r_state == mcsql_pkg::ST_CHK) begin
            r_p_addr <= n_p_addr;
            r_p_next <= n_p_next;
            r_need_n <= n_need_n;
            r_n_addr <= n_n_addr;
            r_n_prev <= n_n_prev;
            r_n_own  <= n_n_own;
            r_res    <= n_res;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mcsql_pkg::ST_IDLE || r_state == mcsql_pkg::ST_DONE) |-> !we)
        else $error("record write outside an update step");

    a_handoff_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_res.hv == (o_res.status == mcsql_pkg::R_HANDOFF)))
        else $error("handoff flag disagrees with status");

    a_neighbor_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mcsql_pkg::ST_RMW_P || r_state == mcsql_pkg::ST_RMW_N)
            |-> waddr != cpu_addr)
        else $error("neighbor update aliases requester record");

    a_tail_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail == '0 || link_ok(r_tail))
        else $error("tail link out of range");
`endif

endmodule

@@ tb/mcs_queue_lock_with_cancel_tb.sv @@
module mcs_queue_lock_with_cancel_tb;

    import mcsql_pkg::*;

    localparam int NCPU        = NUM_CPUS_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_AT     = 2500;
    localparam int HOLD_LEN    = 400;
    localparam int RANDOM_REQS = 1450;

    localparam logic [ACTION_W-1:0] ACT_BAD = 2'd3;

    typedef struct {
        logic [ACTION_W-1:0] act;
        logic [CPU_W-1:0]    cpu;
        bit                  drain_first;
    } t_lock_req;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // action[1:0], cpu[5:2], zero[7:6]
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // status[2:0], handoff_valid[3], handoff_cpu[7:4]

    // pending requests and the shadow queue used to shape them (head = owner)
    t_lock_req req_q[$];
    int        gen_order[$];

    // lock state as the checker sees it
    logic [4:0] lk_tail;
    logic [4:0] lk_next[NCPU];
    logic [4:0] lk_prev[NCPU];
    logic [1:0] lk_stat[NCPU];
    t_result    status_due[$];
    t_result    mon_got, mon_want;

    int mismatches = 0;
    int n_sent = 0, n_done = 0;
    int burst_left = 1, gap_left = 0;
    int rcv_cycles = 0, rcv_mode = 0, hold_left = 0;
    int idle_cycles = 0;

    mcs_queue_lock_with_cancel u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic bit link_ok(input logic [4:0] l);
        return l != 5'd0 && l <= NCPU;
    endfunction

    function automatic t_result lock_step(input logic [ACTION_W-1:0] act,
                                          input logic [CPU_W-1:0] cpu);
        t_result    r;
        logic [4:0] me, p, n;
        bit         hasp;
        r = '{hc: '0, hv: 1'b0, status: R_ERROR};
        me = {1'b0, cpu} + 5'd1;
        if (cpu < NCPU) begin
            case (act)
                ACT_ACQUIRE: if (lk_stat[cpu] == CS_IDLE) begin
                    lk_next[cpu] = 5'd0;
                    if (!link_ok(lk_tail)) begin
                        lk_tail = me;
                        lk_prev[cpu] = 5'd0;
                        lk_stat[cpu] = CS_OWNER;
                        r.status = R_ACQUIRED;
                    end else begin
                        p = lk_tail - 5'd1;
                        lk_prev[cpu] = lk_tail;
                        lk_next[p] = me;
                        lk_tail = me;
                        lk_stat[cpu] = CS_WAIT;
                        r.status = R_QUEUED;
                    end
                end
                ACT_RELEASE: if (lk_stat[cpu] == CS_OWNER) begin
                    if (lk_tail == me || !link_ok(lk_next[cpu])) begin
                        if (lk_tail == me)
                            lk_tail = 5'd0;
                        r.status = R_FREED;
                    end else begin
                        n = lk_next[cpu] - 5'd1;
                        lk_prev[n] = 5'd0;
                        lk_stat[n] = CS_OWNER;
                        r.hv = 1'b1;
                        r.hc = n[CPU_W-1:0];
                        r.status = R_HANDOFF;
                    end
                    lk_next[cpu] = 5'd0;
                    lk_prev[cpu] = 5'd0;
                    lk_stat[cpu] = CS_IDLE;
                end
                ACT_CANCEL: if (lk_stat[cpu] == CS_OWNER) begin
                    r.status = R_OWNER;
                end else if (lk_stat[cpu] == CS_WAIT) begin
                    hasp = link_ok(lk_prev[cpu]);
                    p = lk_prev[cpu] - 5'd1;
                    if (hasp)
                        lk_next[p] = 5'd0;
                    if (lk_tail == me) begin
                        lk_tail = lk_prev[cpu];
                    end else if (link_ok(lk_next[cpu])) begin
                        n = lk_next[cpu] - 5'd1;
                        lk_prev[n] = lk_prev[cpu];
                        if (hasp)
                            lk_next[p] = n + 5'd1;
                    end
                    lk_next[cpu] = 5'd0;
                    lk_prev[cpu] = 5'd0;
                    lk_stat[cpu] = CS_IDLE;
                    r.status = R_CANCELLED;
                end
                default: ;
            endcase
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        mismatches++;
        $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
    endtask

    function automatic int find_cpu(input int cpu);
        foreach (gen_order[i])
            if (gen_order[i] == cpu)
                return i;
        return -1;
    endfunction

    // queue a request and advance the shadow queue; legal = the request does not report error
    task automatic add_req(input logic [ACTION_W-1:0] act, input int cpu,
                           input bit drain, output bit legal);
        int idx;
        idx = find_cpu(cpu);
        legal = 1'b0;
        case (act)
            ACT_ACQUIRE: if (idx < 0) begin
                gen_order.push_back(cpu);
                legal = 1'b1;
            end
            ACT_RELEASE: if (idx == 0) begin
                void'(gen_order.pop_front());
                legal = 1'b1;
            end
            ACT_CANCEL: if (idx >= 0) begin
                if (idx > 0)
                    gen_order.delete(idx);
                legal = 1'b1;
            end
            default: ;
        endcase
        req_q.push_back('{act: act, cpu: cpu[CPU_W-1:0], drain_first: drain});
    endtask

    task automatic add_directed(input logic [ACTION_W-1:0] act, input int cpu);
        bit legal;
        add_req(act, cpu, 1'b0, legal);
    endtask

    function automatic int pick_idle();
        int c;
        do c = $urandom_range(0, NCPU - 1); while (find_cpu(c) >= 0);
        return c;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                void'(req_q.pop_front());
                n_sent++;
            end
            if (m_axis_tvalid && m_axis_tready)
                n_done++;
            if (s_axis_tvalid && !s_axis_tready) begin
                // hold the request until taken
            end else if (req_q.size() == 0) begin
                s_axis_tvalid <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (req_q[0].drain_first && n_done < n_sent) begin
                s_axis_tvalid <= 1'b0;
            end else begin
                req_q[0].drain_first = 1'b0;
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {2'b00, req_q[0].cpu, req_q[0].act};
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            rcv_cycles++;
            if (rcv_cycles == HOLD_AT)
                hold_left = HOLD_LEN;
            if (rcv_cycles % 64 == 0)
                rcv_mode = $urandom_range(0, 2);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                case (rcv_mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // monitor: check results, then predict from accepted requests
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lk_tail = 5'd0;
            foreach (lk_next[i]) begin
                lk_next[i] = 5'd0;
                lk_prev[i] = 5'd0;
                lk_stat[i] = CS_IDLE;
            end
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                mon_got = t_result'(m_axis_tdata);
                if (status_due.size() == 0) begin
                    report_mismatch("unexpected result, status", -1, mon_got.status);
                end else begin
                    mon_want = status_due.pop_front();
                    if (mon_got.status != mon_want.status)
                        report_mismatch("status", mon_want.status, mon_got.status);
                    if (mon_got.hv != mon_want.hv)
                        report_mismatch("handoff_valid", mon_want.hv, mon_got.hv);
                    if (mon_got.hc != mon_want.hc)
                        report_mismatch("handoff_cpu", mon_want.hc, mon_got.hc);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                status_due.push_back(lock_step(s_axis_tdata[1:0], s_axis_tdata[5:2]));
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int  n_legal, r, cpu, sz;
        bit  fill, legal, drain;
        logic [ACTION_W-1:0] act;

        // directed: empty grant, queueing, wrong-state errors, tail/middle cancels,
        // handoffs, owner cancel, unknown action
        add_directed(ACT_ACQUIRE, 0);
        add_directed(ACT_ACQUIRE, 15);
        add_directed(ACT_ACQUIRE, 5);
        add_directed(ACT_ACQUIRE, 0);
        add_directed(ACT_RELEASE, 15);
        add_directed(ACT_CANCEL, 0);
        add_directed(ACT_CANCEL, 3);
        add_directed(ACT_BAD, 7);
        add_directed(ACT_CANCEL, 5);
        add_directed(ACT_ACQUIRE, 5);
        add_directed(ACT_ACQUIRE, 9);
        add_directed(ACT_CANCEL, 5);
        add_directed(ACT_RELEASE, 0);
        add_directed(ACT_RELEASE, 15);
        add_directed(ACT_RELEASE, 9);
        add_directed(ACT_RELEASE, 9);
        add_directed(ACT_ACQUIRE, 3);
        add_directed(ACT_CANCEL, 3);
        add_directed(ACT_RELEASE, 3);
        add_directed(ACT_BAD, 15);
        add_directed(ACT_ACQUIRE, 10);
        add_directed(ACT_ACQUIRE, 11);
        add_directed(ACT_ACQUIRE, 12);
        add_directed(ACT_CANCEL, 11);
        add_directed(ACT_RELEASE, 10);
        add_directed(ACT_RELEASE, 12);

        n_legal = 0;
        fill = 1'b1;
        while (n_legal < RANDOM_REQS) begin
            if ($urandom_range(0, 24) == 0)
                fill = !fill;
            drain = (n_legal == 0 && req_q.size() == 26) || (n_legal == 800);
            r = $urandom_range(0, 99);
            sz = gen_order.size();
            if (r < 8) begin
                act = ACTION_W'($urandom_range(0, 3));
                cpu = $urandom_range(0, NCPU - 1);
            end else begin
                if (fill)
                    r = (r < 70) ? 0 : (r < 80) ? 1 : (r < 93) ? 2 : 3;
                else
                    r = (r < 25) ? 0 : (r < 60) ? 1 : (r < 95) ? 2 : 3;
                if (sz == 0)
                    r = 0;
                else if (r == 0 && sz == NCPU)
                    r = 1;
                else if (r == 2 && sz < 2)
                    r = 1;
                case (r)
                    0: begin act = ACT_ACQUIRE; cpu = pick_idle(); end
                    1: begin act = ACT_RELEASE; cpu = gen_order[0]; end
                    2: begin act = ACT_CANCEL;  cpu = gen_order[$urandom_range(1, sz - 1)]; end
                    default: begin act = ACT_CANCEL; cpu = gen_order[0]; end
                endcase
            end
            add_req(act, cpu, drain, legal);
            if (legal)
                n_legal++;
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (req_q.size() != 0 || s_axis_tvalid || status_due.size() != 0);
        repeat (12) @(negedge i_clk);

        if (mismatches == 0 && status_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
